### rtl/core/vcs_pkg.sv
package vcs_pkg;

    localparam int unsigned ALPHA_SIZE = 149;
    localparam int unsigned IDX_W      = 8;
    localparam int unsigned CP_IN_W    = 16;
    localparam int unsigned CP_OUT_W   = 11;
    localparam int unsigned ROM_DEPTH  = 8;
    localparam int unsigned ROM_IDX_W  = 3;

    // alphabet segments: punctuation/digits, upper Latin, lower Latin, Cyrillic
    localparam logic [CP_IN_W-1:0] SEG0_LO = 16'h0020;
    localparam logic [CP_IN_W-1:0] SEG0_HI = 16'h0040;
    localparam logic [CP_IN_W-1:0] SEG1_LO = 16'h0041;
    localparam logic [CP_IN_W-1:0] SEG1_HI = 16'h005A;
    localparam logic [CP_IN_W-1:0] SEG2_LO = 16'h0061;
    localparam logic [CP_IN_W-1:0] SEG2_HI = 16'h007A;
    localparam logic [CP_IN_W-1:0] SEG3_LO = 16'h0410;
    localparam logic [CP_IN_W-1:0] SEG3_HI = 16'h044F;

    localparam logic [IDX_W-1:0] SEG1_BASE = 8'd33;
    localparam logic [IDX_W-1:0] SEG2_BASE = 8'd59;
    localparam logic [IDX_W-1:0] SEG3_BASE = 8'd85;

    localparam logic [IDX_W-1:0] ALPHA_SIZE_IDX = IDX_W'(ALPHA_SIZE);

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic KEY_MODE_FIELD   = 1'b0;
    localparam logic KEY_MODE_KEYWORD = 1'b1;

    // alphabet indices of the built-in keyword "Ad4\u0434qJ2\u044b"
    localparam logic [IDX_W-1:0] KEY_ROM [ROM_DEPTH] = '{
        8'd33, 8'd62, 8'd20, 8'd121, 8'd75, 8'd42, 8'd18, 8'd144
    };

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } t_sym_idx;

    typedef struct packed {
        logic                 mode;
        logic [IDX_W-1:0]     rom_idx;
    } t_key_sel;

    function automatic t_sym_idx cp_to_index(input logic [CP_IN_W-1:0] cp);
        t_sym_idx res;
        res = '0;
        if (cp >= SEG0_LO && cp <= SEG0_HI) begin
            res.ok  = 1'b1;
            res.idx = IDX_W'(cp - SEG0_LO);
        end else if (cp >= SEG1_LO && cp <= SEG1_HI) begin
            res.ok  = 1'b1;
            res.idx = SEG1_BASE + IDX_W'(cp - SEG1_LO);
        end else if (cp >= SEG2_LO && cp <= SEG2_HI) begin
            res.ok  = 1'b1;
            res.idx = SEG2_BASE + IDX_W'(cp - SEG2_LO);
        end else if (cp >= SEG3_LO && cp <= SEG3_HI) begin
            res.ok  = 1'b1;
            res.idx = SEG3_BASE + IDX_W'(cp - SEG3_LO);
        end
        return res;
    endfunction

    function automatic logic [CP_OUT_W-1:0] index_to_cp(input logic [IDX_W-1:0] idx);
        logic [CP_OUT_W-1:0] cp;
        if (idx < SEG1_BASE) begin
            cp = CP_OUT_W'(SEG0_LO) + CP_OUT_W'(idx);
        end else if (idx < SEG2_BASE) begin
            cp = CP_OUT_W'(SEG1_LO) + CP_OUT_W'(idx - SEG1_BASE);
        end else if (idx < SEG3_BASE) begin
            cp = CP_OUT_W'(SEG2_LO) + CP_OUT_W'(idx - SEG2_BASE);
        end else begin
            cp = CP_OUT_W'(SEG3_LO) + CP_OUT_W'(idx - SEG3_BASE);
        end
        return cp;
    endfunction

endpackage

### rtl/core/vcs_keygen.sv
module vcs_keygen #(
    parameter int unsigned KEYWORD_LENGTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_key_mode,
    input  logic              i_advance,
    input  logic              i_last,
    output vcs_pkg::t_key_sel o_key_sel
);

    localparam int unsigned POS_W = (KEYWORD_LENGTH > 1) ? $clog2(KEYWORD_LENGTH) : 1;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(KEYWORD_LENGTH - 1);

    logic             r_key_mode;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W+vcs_pkg::ROM_IDX_W-1:0] pos_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_mode <= vcs_pkg::KEY_MODE_KEYWORD;
        end else if (i_cfg_we) begin
            r_key_mode <= i_cfg_key_mode;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (i_advance) begin
            if (i_last || r_pos >= POS_MAX) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // ROM is addressed by the position modulo its depth
    assign pos_ext = {{vcs_pkg::ROM_IDX_W{1'b0}}, r_pos};

    assign o_key_sel.mode    = r_key_mode;
    assign o_key_sel.rom_idx = vcs_pkg::KEY_ROM[pos_ext[vcs_pkg::ROM_IDX_W-1:0]];

endmodule

### rtl/core/vcs_cipher.sv
module vcs_cipher (
    input  logic                         i_command,
    input  logic [vcs_pkg::CP_IN_W-1:0]  i_data_char,
    input  logic [vcs_pkg::CP_IN_W-1:0]  i_key_char,
    input  vcs_pkg::t_key_sel            i_key_sel,
    output logic [vcs_pkg::CP_OUT_W-1:0] o_out_char,
    output logic                         o_error
);

    vcs_pkg::t_sym_idx       data_idx;
    vcs_pkg::t_sym_idx       key_idx;
    logic                    key_ok;
    logic [vcs_pkg::IDX_W-1:0] k;
    logic [vcs_pkg::IDX_W:0] sum;
    logic [vcs_pkg::IDX_W:0] diff;
    logic [vcs_pkg::IDX_W-1:0] r;

    always_comb begin
        data_idx = vcs_pkg::cp_to_index(i_data_char);
        key_idx  = vcs_pkg::cp_to_index(i_key_char);
        if (i_key_sel.mode == vcs_pkg::KEY_MODE_KEYWORD) begin
            key_ok = 1'b1;
            k      = i_key_sel.rom_idx;
        end else begin
            key_ok = key_idx.ok;
            k      = key_idx.idx;
        end

        // both operands are below 149, so one correction step is enough
        sum  = {1'b0, data_idx.idx} + {1'b0, k};
        diff = {1'b0, data_idx.idx} - {1'b0, k};
        if (i_command == vcs_pkg::CMD_DECODE) begin
            r = diff[vcs_pkg::IDX_W] ? diff[vcs_pkg::IDX_W-1:0] + vcs_pkg::ALPHA_SIZE_IDX
                                     : diff[vcs_pkg::IDX_W-1:0];
        end else begin
            r = (sum >= {1'b0, vcs_pkg::ALPHA_SIZE_IDX})
                ? vcs_pkg::IDX_W'(sum - {1'b0, vcs_pkg::ALPHA_SIZE_IDX})
                : sum[vcs_pkg::IDX_W-1:0];
        end

        o_error    = !(data_idx.ok && key_ok);
        o_out_char = o_error ? '0 : vcs_pkg::index_to_cp(r);
    end

endmodule

### rtl/core/vigenere_cipher_149_symbol_top.sv
// Vigenere cipher over a 149-symbol alphabet (0x20-0x40, A-Z, a-z, Cyrillic
// 0x410-0x44F). One character per beat on s_axis, one result per beat on
// m_axis; throughput is one character per clock unless m_axis_tready stalls
// the output, through a two-register pipeline (input, then result register).
// The key comes from s_axis_tdata when key_mode is 0, or from the built-in
// 8-symbol keyword when key_mode is 1 (reset value); the keyword position
// steps on every accepted beat, wraps after KEYWORD_LENGTH beats and restarts
// after a beat with tlast set. A character or key outside the alphabet gives
// error = 1 and a zero character. Write key_mode only while the block is idle.
module vigenere_cipher_149_symbol_top #(
    parameter int unsigned KEYWORD_LENGTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,      // key_mode

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [15:0] data_char, [31:16] key_char
    input  logic        s_axis_tuser,    // [0] command
    input  logic        s_axis_tlast,    // last_in

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [10:0] out_char, [15:11] zero
    output logic        m_axis_tuser,    // [0] error
    output logic        m_axis_tlast     // last_out
);

    localparam int unsigned CPI = vcs_pkg::CP_IN_W;
    localparam int unsigned CPO = vcs_pkg::CP_OUT_W;

    vcs_pkg::t_key_sel key_sel;

    logic              r_in_valid;
    logic              r_in_cmd;
    logic [CPI-1:0]    r_in_data;
    logic [CPI-1:0]    r_in_key;
    logic              r_in_last;
    vcs_pkg::t_key_sel r_in_key_sel;

    logic              r_out_valid;
    logic [CPO-1:0]    r_out_char;
    logic              r_out_err;
    logic              r_out_last;

    logic              in_ready;
    logic              out_ready;
    logic              in_fire;
    logic [CPO-1:0]    res_char;
    logic              res_err;

    assign o_cfg_ready   = 1'b1;
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign in_ready      = !r_in_valid || out_ready;
    assign s_axis_tready = in_ready;
    assign in_fire       = s_axis_tvalid && in_ready;

    vcs_keygen #(
        .KEYWORD_LENGTH (KEYWORD_LENGTH)
    ) u_keygen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_key_mode (i_cfg_data),
        .i_advance      (in_fire),
        .i_last         (s_axis_tlast),
        .o_key_sel      (key_sel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_cmd     <= s_axis_tuser;
            r_in_data    <= s_axis_tdata[CPI-1:0];
            r_in_key     <= s_axis_tdata[2*CPI-1:CPI];
            r_in_last    <= s_axis_tlast;
            r_in_key_sel <= key_sel;
        end
    end

    vcs_cipher u_cipher (
        .i_command   (r_in_cmd),
        .i_data_char (r_in_data),
        .i_key_char  (r_in_key),
        .i_key_sel   (r_in_key_sel),
        .o_out_char  (res_char),
        .o_error     (res_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_out_char <= res_char;
            r_out_err  <= res_err;
            r_out_last <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16-CPO){1'b0}}, r_out_char};
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tlast  = r_out_last;

endmodule
